// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLDS(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("property failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("property failed");

`endif

// ===== design/rgbgd_pkg.sv =====
// Shared widths, constants, types and pixel functions of the gray downscaler.
// No dependencies; every design module imports this package.
package rgbgd_pkg;

  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned GRAY_W    = 8;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned STEP_W    = 24;
  localparam int unsigned SX_W      = COORD_W + STEP_W;
  localparam int unsigned POS_W     = SX_W - FRAC_W;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned OUT_SIZE   = 96;
  localparam int unsigned RESET_SIZE = 96;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(OUT_SIZE - 1);

  // Step = ((size - 1) << 16) / (OUT_SIZE - 1), done as a multiply by a rounded-up
  // reciprocal. The numerator fits in SIZE_W + FRAC_W bits, which makes the result exact.
  localparam int unsigned STEP_DIV = OUT_SIZE - 1;
  localparam int unsigned STEP_L   = $clog2(STEP_DIV);
  localparam int unsigned STEP_S   = SIZE_W + FRAC_W + STEP_L;
  localparam int unsigned STEP_M_W = SIZE_W + FRAC_W + 1;
  localparam longint unsigned STEP_M = ((64'd1 << STEP_S) + STEP_DIV - 1) / STEP_DIV;
  localparam int unsigned STEP_SH  = STEP_S - FRAC_W;
  localparam logic [STEP_W-1:0] STEP_RESET =
    STEP_W'(((RESET_SIZE - 1) << FRAC_W) / STEP_DIV);

  // Reciprocals for the exact divisions by 31 and 63 in the color expansion.
  localparam int unsigned RECIP31 = 8457;
  localparam int unsigned SHIFT31 = 18;
  localparam int unsigned RECIP63 = 16645;
  localparam int unsigned SHIFT63 = 20;

  localparam int unsigned WEIGHT_R = 77;
  localparam int unsigned WEIGHT_G = 150;
  localparam int unsigned WEIGHT_B = 29;

  localparam logic [GRAY_W-1:0] GRAY_BIAS = 8'd128;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic              degen;
  } cfg_t;

  function automatic logic [GRAY_W-1:0] expand5(input logic [4:0] v);
    logic [31:0] prod;
    prod = 32'(v) * 32'd255 * 32'(RECIP31);
    return GRAY_W'(prod >> SHIFT31);
  endfunction

  function automatic logic [GRAY_W-1:0] expand6(input logic [5:0] v);
    logic [31:0] prod;
    prod = 32'(v) * 32'd255 * 32'(RECIP63);
    return GRAY_W'(prod >> SHIFT63);
  endfunction

  function automatic logic [GRAY_W-1:0] gray_sum(input logic [GRAY_W-1:0] r,
                                                 input logic [GRAY_W-1:0] g,
                                                 input logic [GRAY_W-1:0] b);
    logic [31:0] sum;
    sum = 32'(r) * 32'(WEIGHT_R) + 32'(g) * 32'(WEIGHT_G) + 32'(b) * 32'(WEIGHT_B);
    return GRAY_W'(sum >> 8);
  endfunction

endpackage

// ===== design/rgb565_gray_bilinear_downscale.sv =====
// RGB565 to gray bilinear downscaler. A load word (func 0) converts one RGB565 pixel to
// gray and writes it to the frame store, busy through its expand and write states. A
// compute word (func 1) returns one 96x96 output sample as gray minus 128 on
// gray_value_o with a one-cycle done_o strobe. It steps through the coordinate and row
// multiplies, the four neighbor reads through the single store port and the shared
// interpolator; start is taken only while the block is idle. With a source width
// or height of one or less a compute returns 0 in the cycle after start, and the next
// word may follow at once. The receiver cannot stall done_o. The frame store is
// not cleared after reset: every source pixel that a compute touches must be loaded first.
module rgb565_gray_bilinear_downscale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rgbgd_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rgbgd_pkg::SIZE_W-1:0]         cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 func_i,
  input  logic [rgbgd_pkg::PIX_W-1:0]          pixel_i,
  input  logic [rgbgd_pkg::ADDR_W-1:0]         src_addr_i,
  input  logic [rgbgd_pkg::COORD_W-1:0]        out_x_i,
  input  logic [rgbgd_pkg::COORD_W-1:0]        out_y_i,
  output logic                                 done_o,
  output logic signed [rgbgd_pkg::GRAY_W-1:0]  gray_value_o
);
  import rgbgd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_EXP, S_LD_WR, S_MAP, S_ROWS, S_RD0, S_RD1, S_RD2, S_RD3,
    S_BOT, S_FIN, S_OUT
  } state_e;

  localparam int unsigned ROW_W = POS_W + SIZE_W;

  cfg_t cfg;

  state_e                    state_q, state_d;
  logic                      done_q, done_d;
  logic signed [GRAY_W-1:0]  gray_q, gray_d;

  logic [PIX_W-1:0]   pix_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [COORD_W-1:0] dx_q, dy_q;
  logic [GRAY_W-1:0]  r8_q, g8_q, b8_q;
  logic [SX_W-1:0]    sx_q, sy_q;
  logic [ADDR_W-1:0]  x0_q, x1_q, row0_q, row1_q;
  logic               yinc_q;
  logic [FRAC_W-1:0]  wx_q, wy_q;
  logic [GRAY_W-1:0]  p00_q, p10_q, top_q;

  logic [POS_W-1:0]   x0, y0, x1;
  logic [POS_W:0]     x0_inc, y0_inc;
  logic [ROW_W-1:0]   row_prod;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [GRAY_W-1:0]  mem_wdata, mem_rdata;

  logic [GRAY_W-1:0]  lerp_a, lerp_b, lerp_y;
  logic [FRAC_W-1:0]  lerp_w;

  rgbgd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rgbgd_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  rgbgd_lerp u_lerp (
    .clk_i (clk_i),
    .a_i   (lerp_a),
    .b_i   (lerp_b),
    .w_i   (lerp_w),
    .y_o   (lerp_y)
  );

  assign busy = (state_q != S_IDLE);

  // Integer source positions; the second neighbor is clamped at the right and lower edge.
  always_comb begin
    x0       = sx_q[SX_W-1:FRAC_W];
    y0       = sy_q[SX_W-1:FRAC_W];
    x0_inc   = (POS_W + 1)'(x0) + 1'b1;
    y0_inc   = (POS_W + 1)'(y0) + 1'b1;
    x1       = (x0_inc < (POS_W + 1)'(cfg.width)) ? POS_W'(x0_inc) : x0;
    row_prod = ROW_W'(y0) * ROW_W'(cfg.width);
  end

  // Store port: the load write, or one of the four neighbor reads.
  always_comb begin
    mem_we    = (state_q == S_LD_WR);
    mem_wdata = gray_sum(r8_q, g8_q, b8_q);
    unique case (state_q)
      S_RD0:   mem_addr = row0_q + x0_q;
      S_RD1:   mem_addr = row0_q + x1_q;
      S_RD2:   mem_addr = row1_q + x0_q;
      S_RD3:   mem_addr = row1_q + x1_q;
      default: mem_addr = addr_q;
    endcase
  end

  // The interpolator blends the top row, then the bottom row, then the two rows.
  always_comb begin
    lerp_a = p00_q;
    lerp_b = mem_rdata;
    lerp_w = wx_q;
    unique case (state_q)
      S_BOT: begin
        lerp_a = p10_q;
      end
      S_FIN: begin
        lerp_a = top_q;
        lerp_b = lerp_y;
        lerp_w = wy_q;
      end
      default: begin
        lerp_a = p00_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    gray_d  = gray_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (func_i == FUNC_LOAD) begin
            state_d = S_LD_EXP;
          end else if (cfg.degen) begin
            done_d = 1'b1;
            gray_d = '0;
          end else begin
            state_d = S_MAP;
          end
        end
      end
      S_LD_EXP: state_d = S_LD_WR;
      S_LD_WR:  state_d = S_IDLE;
      S_MAP:    state_d = S_ROWS;
      S_ROWS:   state_d = S_RD0;
      S_RD0:    state_d = S_RD1;
      S_RD1:    state_d = S_RD2;
      S_RD2:    state_d = S_RD3;
      S_RD3:    state_d = S_BOT;
      S_BOT:    state_d = S_FIN;
      S_FIN:    state_d = S_OUT;
      S_OUT: begin
        done_d  = 1'b1;
        gray_d  = $signed(lerp_y - GRAY_BIAS);
        state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      gray_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      gray_q  <= gray_d;
    end
  end

  // Datapath registers. Read data from the store is registered and shows up in the state after its address.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pix_q  <= pixel_i;
        addr_q <= src_addr_i;
        dx_q   <= (out_x_i > COORD_MAX) ? COORD_MAX : out_x_i;
        dy_q   <= (out_y_i > COORD_MAX) ? COORD_MAX : out_y_i;
      end
      S_LD_EXP: begin
        r8_q <= expand5(pix_q[15:11]);
        g8_q <= expand6(pix_q[10:5]);
        b8_q <= expand5(pix_q[4:0]);
      end
      S_MAP: begin
        sx_q <= SX_W'(dx_q) * SX_W'(cfg.x_step);
        sy_q <= SX_W'(dy_q) * SX_W'(cfg.y_step);
      end
      S_ROWS: begin
        x0_q   <= ADDR_W'(x0);
        x1_q   <= ADDR_W'(x1);
        row0_q <= row_prod[ADDR_W-1:0];
        yinc_q <= (y0_inc < (POS_W + 1)'(cfg.height));
        wx_q   <= sx_q[FRAC_W-1:0];
        wy_q   <= sy_q[FRAC_W-1:0];
      end
      S_RD0: begin
        row1_q <= row0_q + (yinc_q ? ADDR_W'(cfg.width) : '0);
      end
      S_RD1: begin
        p00_q <= mem_rdata;
      end
      S_RD3: begin
        p10_q <= mem_rdata;
        top_q <= lerp_y;
      end
      default: begin
        top_q <= top_q;
      end
    endcase
  end

  assign done_o       = done_q;
  assign gray_value_o = gray_q;

endmodule

// ===== design/rgbgd_cfg.sv =====
// Size registers and their Q16 steps; a write recomputes the step of that axis.
// Depends on rgbgd_pkg.
module rgbgd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rgbgd_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rgbgd_pkg::SIZE_W-1:0]       cfg_wdata_i,
  output rgbgd_pkg::cfg_t                    cfg_o
);
  import rgbgd_pkg::*;

  localparam int unsigned PROD_W = SIZE_W + STEP_M_W;

  logic [SIZE_W-1:0] sat_size;
  logic [SIZE_W-1:0] size_m1;
  logic [PROD_W-1:0] step_prod;
  logic [STEP_W-1:0] new_step;

  logic [SIZE_W-1:0] width_q, width_d, height_q, height_d;
  logic [STEP_W-1:0] x_step_q, x_step_d, y_step_q, y_step_d;

  always_comb begin
    sat_size = cfg_wdata_i;
    unique case (cfg_idx_i)
      REG_SRC_WIDTH: begin
        if (32'(cfg_wdata_i) > MAX_WIDTH) sat_size = SIZE_W'(MAX_WIDTH);
      end
      REG_SRC_HEIGHT: begin
        if (32'(cfg_wdata_i) > MAX_HEIGHT) sat_size = SIZE_W'(MAX_HEIGHT);
      end
    endcase
    // A size of zero or one gives a zero step.
    size_m1   = (sat_size == '0) ? '0 : sat_size - 1'b1;
    step_prod = PROD_W'(size_m1) * PROD_W'(STEP_M);
    new_step  = STEP_W'(step_prod >> STEP_SH);
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    x_step_d = x_step_q;
    y_step_d = y_step_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH: begin
          width_d  = sat_size;
          x_step_d = new_step;
        end
        REG_SRC_HEIGHT: begin
          height_d = sat_size;
          y_step_d = new_step;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(RESET_SIZE);
      height_q <= SIZE_W'(RESET_SIZE);
      x_step_q <= STEP_RESET;
      y_step_q <= STEP_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      x_step_q <= x_step_d;
      y_step_q <= y_step_d;
    end
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;
  assign cfg_o.x_step = x_step_q;
  assign cfg_o.y_step = y_step_q;
  assign cfg_o.degen  = (width_q <= SIZE_W'(1)) || (height_q <= SIZE_W'(1));

endmodule

// ===== design/rgbgd_store.sv =====
// Single-port gray frame store with a registered read; not cleared at reset.
// Depends on rgbgd_pkg.
module rgbgd_store (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [rgbgd_pkg::ADDR_W-1:0]     addr_i,
  input  logic [rgbgd_pkg::GRAY_W-1:0]     wdata_i,
  output logic [rgbgd_pkg::GRAY_W-1:0]     rdata_o
);
  import rgbgd_pkg::*;

  logic [GRAY_W-1:0] mem_q [STORE_DEPTH];
  logic [GRAY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rgbgd_lerp.sv =====
// Shared linear interpolator: y = a + floor((b - a) * w / 2^16), registered.
// Depends on rgbgd_pkg.
module rgbgd_lerp (
  input  logic                             clk_i,
  input  logic [rgbgd_pkg::GRAY_W-1:0]     a_i,
  input  logic [rgbgd_pkg::GRAY_W-1:0]     b_i,
  input  logic [rgbgd_pkg::FRAC_W-1:0]     w_i,
  output logic [rgbgd_pkg::GRAY_W-1:0]     y_o
);
  import rgbgd_pkg::*;

  logic signed [GRAY_W:0]          diff;
  logic signed [GRAY_W+FRAC_W+1:0] prod;
  logic signed [GRAY_W+1:0]        delta;
  logic        [GRAY_W+1:0]        sum;
  logic        [GRAY_W-1:0]        y_q;

  // a*(1-w) + b*w equals a + (b-a)*w; the arithmetic shift gives the floor.
  always_comb begin
    diff  = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
    prod  = diff * $signed({1'b0, w_i});
    delta = (GRAY_W + 2)'(prod >>> FRAC_W);
    sum   = {2'b00, a_i} + $unsigned(delta);
  end

  always_ff @(posedge clk_i) begin
    y_q <= sum[GRAY_W-1:0];
  end

  assign y_o = y_q;

endmodule

// ===== design/rgbgd_chk.sv =====
// Port-level checker for the gray downscaler, bound to the top level.
// Depends on rgbgd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rgbgd_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic func_i,
  input logic done_o
);
  import rgbgd_pkg::*;

  logic accept_load;
  logic accept_compute;

  assign accept_load    = start && !busy && (func_i == FUNC_LOAD);
  assign accept_compute = start && !busy && (func_i == FUNC_COMPUTE);

  // A result word always lands in a cycle where a new word can be taken.
  `ASSERT_HOLDS(done_not_busy_a, done_o, !busy)
  // A load keeps the block busy and never produces a word.
  `ASSERT_NEXT(load_no_result_a, accept_load, busy && !done_o)
  // A compute either enters the sequencer or answers at once.
  `ASSERT_NEXT(compute_responds_a, accept_compute, busy || done_o)
  // Every result word follows a compute or the end of a busy stretch.
  `ASSERT_HOLDS(done_has_cause_a, done_o, $past(busy) || $past(accept_compute))

endmodule

bind rgb565_gray_bilinear_downscale rgbgd_chk u_rgbgd_chk (.*);
